// File: hdl/dib_pixel_to_rgba_assert.svh
// ----------------------------------------------------------------------------
// dib_pixel_to_rgba_assert.svh
// Assertion macros for the DIB pixel decoder: same-cycle and next-cycle
// implications, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIB_PIXEL_TO_RGBA_ASSERT_SVH
`define DIB_PIXEL_TO_RGBA_ASSERT_SVH

// check cons in the cycle where ante holds
`define DPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante holds
`define DPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/dpr_pkg.sv
// ----------------------------------------------------------------------------
// dpr_pkg
// Shared types, codes and functions of the DIB pixel decoder: register
// indexes, pixel modes, status codes, bit-field descriptors and scale tables.
// ----------------------------------------------------------------------------
package dpr_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int PALETTE_WIDTH     = 24;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RED_MASK     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_MASK   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_MASK    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_FIELD  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_SIZE = 3'd5;

    localparam logic [2:0] MODE_1BPP  = 3'd0;
    localparam logic [2:0] MODE_4BPP  = 3'd1;
    localparam logic [2:0] MODE_8BPP  = 3'd2;
    localparam logic [2:0] MODE_16BPP = 3'd3;
    localparam logic [2:0] MODE_24BPP = 3'd4;
    localparam logic [2:0] MODE_32BPP = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [1:0] STATUS_BAD_MASK  = 2'd2;

    localparam logic FUNC_DECODE  = 1'b0;
    localparam logic FUNC_PALETTE = 1'b1;

    localparam logic [31:0] RED_MASK_RST    = 32'h00FF_0000;
    localparam logic [31:0] GREEN_MASK_RST  = 32'h0000_FF00;
    localparam logic [31:0] BLUE_MASK_RST   = 32'h0000_00FF;
    localparam logic [31:0] ALPHA_FIELD_RST = 32'h0000_0000;
    localparam logic [8:0]  PALETTE_SIZE_RST = 9'd256;

    typedef struct packed {
        logic       present;
        logic       contig;
        logic       fits16;
        logic       narrow;
        logic [2:0] nbits;
        logic [4:0] sx;
        logic [7:0] lmask;
    } t_field_info;

    typedef logic [7:0] t_lut [0:127];

    function automatic t_lut build_lut(input int unsigned b);
        t_lut lut;
        for (int i = 0; i < 128; i++) begin
            case (b)
                3: lut[i] = 8'((i * 255) / 7);
                5: lut[i] = 8'((i * 255) / 31);
                6: lut[i] = 8'((i * 255) / 63);
                default: lut[i] = 8'((i * 255) / 127);
            endcase
        end
        return lut;
    endfunction

    localparam t_lut LUT3 = build_lut(3);
    localparam t_lut LUT5 = build_lut(5);
    localparam t_lut LUT6 = build_lut(6);
    localparam t_lut LUT7 = build_lut(7);

    function automatic logic [7:0] scale_field(input logic [2:0] nb, input logic [6:0] v);
        logic [7:0] s;
        case (nb)
            3'd1: s = {8{v[0]}};
            3'd2: s = {4{v[1:0]}};
            3'd3: s = LUT3[v];
            3'd4: s = {2{v[3:0]}};
            3'd5: s = LUT5[v];
            3'd6: s = LUT6[v];
            3'd7: s = LUT7[v];
            default: s = 8'd0;
        endcase
        return s;
    endfunction

    function automatic t_field_info mask_info(input logic [31:0] m);
        logic [31:0] low_bit;
        logic [31:0] below;
        logic [5:0]  sh;
        logic [5:0]  bits;
        logic [6:0]  top;
        t_field_info f;
        low_bit  = m & (~m + 32'd1);
        below    = low_bit - 32'd1;
        sh       = 6'($countones(below));
        bits     = 6'($countones(m));
        top      = 7'(sh) + 7'(bits);
        f.present = (m != 32'd0);
        f.contig  = (((m + low_bit) & m) == 32'd0);
        f.fits16  = (top <= 7'd16);
        f.narrow  = (bits < 6'd8);
        f.nbits   = bits[2:0];
        f.sx      = f.narrow ? sh[4:0] : 5'(top - 7'd8);
        f.lmask   = f.narrow ? ~(8'hFF << bits[2:0]) : 8'hFF;
        return f;
    endfunction

    function automatic logic field_ok(input t_field_info f, input logic is16);
        return !f.present || (f.contig && (!is16 || f.fits16));
    endfunction

endpackage

// File: hdl/dpr_ram.sv
// ----------------------------------------------------------------------------
// dpr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dpr_ram #(
    parameter int  WIDTH = dpr_pkg::PALETTE_WIDTH,
    parameter int  DEPTH = dpr_pkg::PALETTE_DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/dpr_field.sv
// ----------------------------------------------------------------------------
// dpr_field
// Bit-field channel extractor: shifts the field down, keeps its top eight
// bits or scales a narrow field up to the full 8-bit range.
// ----------------------------------------------------------------------------
module dpr_field (
    input  logic [31:0]         i_word,
    input  dpr_pkg::t_field_info i_info,
    input  logic [7:0]          i_absent,
    output logic [7:0]          o_value
);

    logic [31:0] shifted;
    logic [7:0]  raw;
    logic [7:0]  value;

    always_comb begin
        shifted = i_word >> i_info.sx;
        raw     = shifted[7:0] & i_info.lmask;
        value   = i_info.narrow ? dpr_pkg::scale_field(i_info.nbits, raw[6:0]) : raw;
        o_value = i_info.present ? value : i_absent;
    end

endmodule

// File: hdl/dib_pixel_to_rgba.sv
// ----------------------------------------------------------------------------
// dib_pixel_to_rgba
// Decodes one bitmap pixel per item to 8-bit RGBA: palette lookup for 1, 4
// and 8 bpp, BGR bytes for 24 bpp, bit fields for 16 and 32 bpp.
//
// channel  direction  handshake                   payload
// in       sink       i_in_valid / o_in_stall     func, pixel data, position, index, first
// out      source     o_out_valid / i_out_stall   red, green, blue, alpha, status, alpha seen
// cfg      sink       i_cfg_wr_en                 register index, write data
//
// A decode item is registered in stage 1 and then in the output register. One
// item per cycle while the output is not stalled: the palette RAM read port is
// used once per item. Palette writes give no output.
// Reset restores register defaults and clears the alpha-seen flag; the
// palette is not cleared. A stalled output holds; the input stalls while
// both stages hold an item and the output is stalled.
// ----------------------------------------------------------------------------
module dib_pixel_to_rgba #(
    parameter int PALETTE_DEPTH = dpr_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [dpr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dpr_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_func,
    input  logic [31:0]                    i_pixel_data,
    input  logic [2:0]                     i_sub_position,
    input  logic [7:0]                     i_palette_index,
    input  logic                           i_first_of_image,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_red,
    output logic [7:0]                     o_green,
    output logic [7:0]                     o_blue,
    output logic [7:0]                     o_alpha,
    output logic [1:0]                     o_status,
    output logic                           o_alpha_seen
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);
    localparam int PALETTE_WIDTH_L = dpr_pkg::PALETTE_WIDTH;

    logic [2:0]           r_pixel_mode;
    logic [8:0]           r_palette_size;
    dpr_pkg::t_field_info r_red_info;
    dpr_pkg::t_field_info r_green_info;
    dpr_pkg::t_field_info r_blue_info;
    dpr_pkg::t_field_info r_alpha_info;

    logic        r_s1_valid;
    logic        r_s1_bad_idx;
    logic        r_s1_first;
    logic [31:0] r_s1_word;
    logic        r_alpha_seen;

    logic        r_o_valid;
    logic [7:0]  r_o_red;
    logic [7:0]  r_o_green;
    logic [7:0]  r_o_blue;
    logic [7:0]  r_o_alpha;
    logic [1:0]  r_o_status;
    logic        r_o_alpha_seen;

    logic        w_out_adv;
    logic        w_s1_adv;
    logic        w_in_accept;
    logic        w_indexed;
    logic [7:0]  w_idx;
    logic [8:0]  w_limit;
    logic        w_idx_bad;
    logic        w_pal_wr;
    logic        w_pal_rd;
    logic [PALETTE_WIDTH_L-1:0] w_pal_data;

    logic [7:0]  w_f_red;
    logic [7:0]  w_f_green;
    logic [7:0]  w_f_blue;
    logic [7:0]  w_f_alpha;

    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;
    logic [7:0]  n_alpha;
    logic [1:0]  n_status;
    logic        n_alpha_seen;
    logic        is16;
    logic        masks_ok;

    // handshake
    assign w_out_adv   = !r_o_valid || !i_out_stall;
    assign w_s1_adv    = r_s1_valid && w_out_adv;
    assign o_in_stall  = r_s1_valid && !w_out_adv;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode   <= dpr_pkg::MODE_32BPP;
            r_palette_size <= dpr_pkg::PALETTE_SIZE_RST;
            r_red_info     <= dpr_pkg::mask_info(dpr_pkg::RED_MASK_RST);
            r_green_info   <= dpr_pkg::mask_info(dpr_pkg::GREEN_MASK_RST);
            r_blue_info    <= dpr_pkg::mask_info(dpr_pkg::BLUE_MASK_RST);
            r_alpha_info   <= dpr_pkg::mask_info(dpr_pkg::ALPHA_FIELD_RST);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                dpr_pkg::CFG_PIXEL_MODE:   r_pixel_mode   <= i_cfg_wr_data[2:0];
                dpr_pkg::CFG_RED_MASK:     r_red_info     <= dpr_pkg::mask_info(i_cfg_wr_data);
                dpr_pkg::CFG_GREEN_MASK:   r_green_info   <= dpr_pkg::mask_info(i_cfg_wr_data);
                dpr_pkg::CFG_BLUE_MASK:    r_blue_info    <= dpr_pkg::mask_info(i_cfg_wr_data);
                dpr_pkg::CFG_ALPHA_FIELD:  r_alpha_info   <= dpr_pkg::mask_info(i_cfg_wr_data);
                dpr_pkg::CFG_PALETTE_SIZE: r_palette_size <= i_cfg_wr_data[8:0];
                default: ;
            endcase
        end
    end

    // palette index and lookup
    always_comb begin
        w_indexed = (r_pixel_mode inside {dpr_pkg::MODE_1BPP, dpr_pkg::MODE_4BPP,
                                          dpr_pkg::MODE_8BPP});
        case (r_pixel_mode)
            dpr_pkg::MODE_1BPP: w_idx = {7'd0, i_pixel_data[~i_sub_position]};
            dpr_pkg::MODE_4BPP: w_idx = i_sub_position[0] ? {4'd0, i_pixel_data[3:0]}
                                                          : {4'd0, i_pixel_data[7:4]};
            default:            w_idx = i_pixel_data[7:0];
        endcase
        w_limit   = (r_palette_size > DEPTH9) ? DEPTH9 : r_palette_size;
        w_idx_bad = ({1'b0, w_idx} >= w_limit);
        w_pal_wr  = w_in_accept && (i_func == dpr_pkg::FUNC_PALETTE)
                    && ({1'b0, i_palette_index} < DEPTH9);
        w_pal_rd  = w_in_accept && (i_func == dpr_pkg::FUNC_DECODE) && w_indexed;
    end

    dpr_ram #(
        .WIDTH (PALETTE_WIDTH_L),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (w_pal_wr),
        .i_wr_addr (i_palette_index[AW-1:0]),
        .i_wr_data (i_pixel_data[PALETTE_WIDTH_L-1:0]),
        .i_rd_en   (w_pal_rd),
        .i_rd_addr (w_idx[AW-1:0]),
        .o_rd_data (w_pal_data)
    );

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= (i_func == dpr_pkg::FUNC_DECODE);
        end else if (w_out_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && (i_func == dpr_pkg::FUNC_DECODE)) begin
            r_s1_bad_idx <= w_idx_bad;
            r_s1_first   <= i_first_of_image;
            r_s1_word    <= i_pixel_data;
        end
    end

    dpr_field u_field_red (
        .i_word (r_s1_word), .i_info (r_red_info), .i_absent (8'h00), .o_value (w_f_red)
    );
    dpr_field u_field_green (
        .i_word (r_s1_word), .i_info (r_green_info), .i_absent (8'h00), .o_value (w_f_green)
    );
    dpr_field u_field_blue (
        .i_word (r_s1_word), .i_info (r_blue_info), .i_absent (8'h00), .o_value (w_f_blue)
    );
    dpr_field u_field_alpha (
        .i_word (r_s1_word), .i_info (r_alpha_info), .i_absent (8'hFF), .o_value (w_f_alpha)
    );

    always_comb begin
        n_red        = 8'h00;
        n_green      = 8'h00;
        n_blue       = 8'h00;
        n_alpha      = 8'hFF;
        n_status     = dpr_pkg::STATUS_OK;
        n_alpha_seen = r_s1_first ? 1'b0 : r_alpha_seen;
        is16         = (r_pixel_mode == dpr_pkg::MODE_16BPP);
        masks_ok     = dpr_pkg::field_ok(r_red_info, is16)
                       && dpr_pkg::field_ok(r_green_info, is16)
                       && dpr_pkg::field_ok(r_blue_info, is16)
                       && dpr_pkg::field_ok(r_alpha_info, is16);
        if (w_indexed) begin
            if (r_s1_bad_idx) begin
                n_status = dpr_pkg::STATUS_BAD_INDEX;
            end else begin
                n_red   = w_pal_data[23:16];
                n_green = w_pal_data[15:8];
                n_blue  = w_pal_data[7:0];
            end
        end else if (r_pixel_mode == dpr_pkg::MODE_24BPP) begin
            n_red   = r_s1_word[23:16];
            n_green = r_s1_word[15:8];
            n_blue  = r_s1_word[7:0];
        end else if (!masks_ok) begin
            n_status = dpr_pkg::STATUS_BAD_MASK;
        end else begin
            n_red   = w_f_red;
            n_green = w_f_green;
            n_blue  = w_f_blue;
            n_alpha = w_f_alpha;
            if (r_alpha_info.present && (w_f_alpha != 8'h00)) begin
                n_alpha_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_seen <= 1'b0;
        end else if (w_s1_adv) begin
            r_alpha_seen <= n_alpha_seen;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_o_red        <= n_red;
            r_o_green      <= n_green;
            r_o_blue       <= n_blue;
            r_o_alpha      <= n_alpha;
            r_o_status     <= n_status;
            r_o_alpha_seen <= n_alpha_seen;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_red        = r_o_red;
    assign o_green      = r_o_green;
    assign o_blue       = r_o_blue;
    assign o_alpha      = r_o_alpha;
    assign o_status     = r_o_status;
    assign o_alpha_seen = r_o_alpha_seen;

`include "dib_pixel_to_rgba_assert.svh"

    `DPR_ASSERT_NOW(a_error_blank, r_o_valid && (r_o_status != dpr_pkg::STATUS_OK), (r_o_red == 8'h00) && (r_o_green == 8'h00) && (r_o_blue == 8'h00) && (r_o_alpha == 8'hFF), "error item not blanked")
    `DPR_ASSERT_NEXT(a_s1_hold, r_s1_valid && !w_out_adv, r_s1_valid, "stage 1 item dropped")
    `DPR_ASSERT_NEXT(a_palette_silent, w_in_accept && (i_func == dpr_pkg::FUNC_PALETTE), !r_s1_valid, "palette write produced an item")
    `DPR_ASSERT_NOW(a_out_source, w_s1_adv, !r_o_valid || !i_out_stall, "output overwritten while stalled")

endmodule
